// ----- hdl/mmtd_pkg.sv -----
`timescale 1ns / 1ps

package mmtd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE  = 2'd1;
    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd2;

    localparam int THRESHOLD_BITS    = 24;
    localparam int WINDOW_SIZE_BITS  = 6;
    localparam int BLOCK_LENGTH_BITS = 16;
    localparam int CFG_INDEX_BITS    = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DROP,
        ST_INSERT,
        ST_RESULT
    } state_t;

    // Operation broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic age;
        logic drop;
        logic insert;
    } cell_ctrl_t;

endpackage

// ----- hdl/mmtd_cell.sv -----
`timescale 1ns / 1ps

module mmtd_cell
    import mmtd_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int AW          = 6
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctrl_t                    ctrl,
    input  logic [AW-1:0]                 limit,
    input  logic signed [SAMPLE_BITS-1:0] new_value,
    input  logic                          kill_below,
    input  logic                          lo_valid,
    input  logic signed [SAMPLE_BITS-1:0] lo_value,
    input  logic [AW-1:0]                 lo_age,
    input  logic                          hi_valid,
    input  logic signed [SAMPLE_BITS-1:0] hi_value,
    input  logic [AW-1:0]                 hi_age,
    output logic                          valid,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic [AW-1:0]                 age,
    output logic                          kill_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic [AW-1:0]                 age_reg;
    logic [AW-1:0]                 age_next;
    logic                          own_kill;
    logic                          shift;
    logic                          keep_own;
    logic                          take_new;

    assign own_kill = valid_reg && (age_reg >= limit);
    assign kill_out = kill_below || own_kill;
    assign shift    = kill_out;
    assign keep_own = valid_reg && (value_reg <= new_value);
    assign take_new = lo_valid && (lo_value <= new_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.age)
        begin
            if (valid_reg)
            begin
                age_next = age_reg + AW'(1);
            end
        end
        else if (ctrl.drop)
        begin
            if (shift)
            begin
                valid_next = hi_valid;
                value_next = hi_value;
                age_next   = hi_age;
            end
        end
        else if (ctrl.insert)
        begin
            if (!keep_own)
            begin
                if (take_new)
                begin
                    valid_next = 1'b1;
                    value_next = new_value;
                    age_next   = '0;
                end
                else
                begin
                    valid_next = lo_valid;
                    value_next = lo_value;
                    age_next   = lo_age;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

// ----- hdl/median_min_threshold_detector.sv -----
`timescale 1ns / 1ps

// An accepted sample passes through the drop, insert and result states before
// the result beat is registered; the drop state repeats while aged-out samples
// are dropped after the window size shrinks. The sorted cell chain handles one
// sample at a time, so a new sample is accepted only after the result is loaded.
// Reset empties the window and loads the register defaults.
module median_min_threshold_detector
    import mmtd_pkg::*;
#(
    parameter int WINDOW_MAX  = 32,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
    input  logic [THRESHOLD_BITS-1:0]             cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // median
    output logic                                  m_tuser,   // status
    output logic                                  m_tlast    // decided
);

    localparam int DW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW  = $clog2(WINDOW_MAX + 1);
    localparam int IW  = ($clog2(WINDOW_MAX) > 0) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW  = (AW > WINDOW_SIZE_BITS) ? AW : WINDOW_SIZE_BITS;
    localparam int CW  = ((SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS) + 1;
    localparam int BCW = BLOCK_LENGTH_BITS + 1;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [THRESHOLD_BITS-1:0]    threshold_reg;
    logic [WINDOW_SIZE_BITS-1:0]         window_size_reg;
    logic [BLOCK_LENGTH_BITS-1:0]        block_length_reg;

    state_t                              state_reg;
    state_t                              state_next;
    cell_ctrl_t                          ctrl;

    logic signed [SAMPLE_BITS-1:0]       sample_reg;
    logic [AW-1:0]                       fill_reg;
    logic [AW-1:0]                       fill_next;
    logic [AW-1:0]                       limit;
    logic [LW-1:0]                       ws_ext;

    logic signed [SAMPLE_BITS-1:0]       block_min_reg;
    logic signed [SAMPLE_BITS-1:0]       block_min_next;
    logic [BCW-1:0]                      block_cnt_reg;
    logic [BCW-1:0]                      block_cnt_next;
    logic                                status_reg;
    logic                                status_next;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [SAMPLE_BITS-1:0]              median_reg;
    logic                                decided_reg;

    logic                                cell_valid [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0]       cell_value [WINDOW_MAX];
    logic [AW-1:0]                       cell_age   [WINDOW_MAX];
    logic                                cell_kill  [WINDOW_MAX];
    logic                                any_kill;

    logic                                accept;
    logic                                load;
    logic [IW-1:0]                       med_idx;
    logic signed [SAMPLE_BITS-1:0]       med;
    logic signed [SAMPLE_BITS-1:0]       min_upd;
    logic [BCW-1:0]                      cnt_inc;
    logic                                decide;
    logic signed [CW-1:0]                min_cmp;
    logic signed [CW-1:0]                thr_cmp;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= '0;
            window_size_reg  <= WINDOW_SIZE_BITS'(1);
            block_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_data;
                REG_WINDOW_SIZE:  window_size_reg  <= cfg_data[WINDOW_SIZE_BITS-1:0];
                REG_BLOCK_LENGTH: block_length_reg <= cfg_data[BLOCK_LENGTH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // A window size of zero acts as one; sizes above the chain length saturate.
    assign ws_ext = LW'(window_size_reg);
    always_comb
    begin
        if (ws_ext == '0)
        begin
            limit = AW'(1);
        end
        else if (ws_ext > LW'(WINDOW_MAX))
        begin
            limit = AW'(WINDOW_MAX);
        end
        else
        begin
            limit = AW'(ws_ext);
        end
    end

    // Sorted chain: ascending values, valid cells packed at the low end.
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            logic                          lo_valid;
            logic signed [SAMPLE_BITS-1:0] lo_value;
            logic [AW-1:0]                 lo_age;
            logic                          hi_valid;
            logic signed [SAMPLE_BITS-1:0] hi_value;
            logic [AW-1:0]                 hi_age;
            logic                          kill_below;

            if (gi == 0)
            begin : g_first
                assign lo_valid   = 1'b1;
                assign lo_value   = SAMPLE_BOT;
                assign lo_age     = '0;
                assign kill_below = 1'b0;
            end
            else
            begin : g_inner_lo
                assign lo_valid   = cell_valid[gi-1];
                assign lo_value   = cell_value[gi-1];
                assign lo_age     = cell_age[gi-1];
                assign kill_below = cell_kill[gi-1];
            end

            if (gi == WINDOW_MAX - 1)
            begin : g_last
                assign hi_valid = 1'b0;
                assign hi_value = SAMPLE_BOT;
                assign hi_age   = '0;
            end
            else
            begin : g_inner_hi
                assign hi_valid = cell_valid[gi+1];
                assign hi_value = cell_value[gi+1];
                assign hi_age   = cell_age[gi+1];
            end

            mmtd_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .AW          (AW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .limit      (limit),
                .new_value  (sample_reg),
                .kill_below (kill_below),
                .lo_valid   (lo_valid),
                .lo_value   (lo_value),
                .lo_age     (lo_age),
                .hi_valid   (hi_valid),
                .hi_value   (hi_value),
                .hi_age     (hi_age),
                .valid      (cell_valid[gi]),
                .value      (cell_value[gi]),
                .age        (cell_age[gi]),
                .kill_out   (cell_kill[gi])
            );
        end
    endgenerate

    assign any_kill = cell_kill[WINDOW_MAX-1];
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_RESULT) && (!out_valid_reg || m_tready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DROP;
                end
            end
            ST_DROP:
            begin
                if (!any_kill)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        s_tready    = 1'b0;
        ctrl.age    = 1'b0;
        ctrl.drop   = 1'b0;
        ctrl.insert = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                ctrl.age = s_tvalid;
            end
            ST_DROP:
            begin
                ctrl.drop = 1'b1;
            end
            ST_INSERT:
            begin
                ctrl.insert = 1'b1;
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if ((state_reg == ST_DROP) && any_kill)
        begin
            fill_next = fill_reg - AW'(1);
        end
        else if (state_reg == ST_INSERT)
        begin
            fill_next = fill_reg + AW'(1);
        end
    end

    // Median selection and block decision.
    assign med_idx        = IW'(fill_reg >> 1);
    assign med            = cell_value[med_idx];
    assign min_upd        = (med < block_min_reg) ? med : block_min_reg;
    assign cnt_inc        = block_cnt_reg + BCW'(1);
    assign decide         = cnt_inc > BCW'(block_length_reg);
    assign min_cmp        = CW'(min_upd);
    assign thr_cmp        = CW'(threshold_reg);
    assign status_next    = decide ? (min_cmp > thr_cmp) : status_reg;
    assign block_min_next = decide ? SAMPLE_TOP : min_upd;
    assign block_cnt_next = decide ? '0 : cnt_inc;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            block_min_reg <= SAMPLE_TOP;
            block_cnt_reg <= '0;
            status_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                block_min_reg <= block_min_next;
                block_cnt_reg <= block_cnt_next;
                status_reg    <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (load)
        begin
            median_reg  <= med;
            decided_reg <= decide;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'(median_reg);
    assign m_tuser  = status_reg;
    assign m_tlast  = decided_reg;

endmodule
